/* design/atint_pkg.sv */
// ----------------------------------------------------------------------------
// atint_pkg
// Shared constants, tables and types of the attenuation table interpolator:
// the breakpoint energies, the per-segment widths and reciprocals, and the
// Q.24 coefficient tables.
// ----------------------------------------------------------------------------
`default_nettype none

package atint_pkg;

	localparam int NUM_POINTS      = 7;
	localparam int NUM_SEGS        = NUM_POINTS - 1;
	localparam int NUM_COEFFS      = 3;
	localparam int COMPTON         = 0;
	localparam int PAIR            = 1;
	localparam int PHOTO           = 2;
	localparam int COEFF_FRAC_BITS = 16;
	localparam int TABLE_FRAC_BITS = 24;
	localparam int FRAC_DROP       = TABLE_FRAC_BITS - COEFF_FRAC_BITS;

	localparam int NUM_STAGES = 8;

	localparam int EW    = 20;
	localparam int OW    = 24;
	localparam int CW    = 32;
	localparam int DW    = 18;
	localparam int RW    = 27;
	localparam int PW    = CW + DW;
	localparam int NW    = PW - FRAC_DROP;
	localparam int HW    = NW / 2;
	localparam int PPH   = (NW - HW) + RW;
	localparam int PPL   = HW + RW;
	localparam int SW    = NW + RW;
	localparam int MW    = RW + DW;
	localparam int REM_W = DW + 1;
	localparam int SEG_W = $clog2(NUM_SEGS);
	localparam int PT_W  = $clog2(NUM_POINTS);

	function automatic logic [CW-1:0] qmicro(input logic [63:0] m);
		logic [63:0] t;
		t = (m * 64'd16777216 + 64'd500000) / 64'd1000000;
		return t[CW-1:0];
	endfunction

	localparam logic [EW-1:0] BRK_EV [NUM_POINTS] = '{
		20'd10000, 20'd50000, 20'd100000, 20'd200000, 20'd400000, 20'd500000, 20'd662000
	};

	localparam logic [DW-1:0] SEG_WIDTH [NUM_SEGS] = '{
		18'd40000, 18'd50000, 18'd100000, 18'd200000, 18'd100000, 18'd162000
	};

	localparam logic [RW-1:0] SEG_RECIP [NUM_SEGS] = '{
		RW'((64'd1 << NW) / 64'd40000),
		RW'((64'd1 << NW) / 64'd50000),
		RW'((64'd1 << NW) / 64'd100000),
		RW'((64'd1 << NW) / 64'd200000),
		RW'((64'd1 << NW) / 64'd100000),
		RW'((64'd1 << NW) / 64'd162000)
	};

	localparam logic [CW-1:0] COEFF_Q24 [NUM_COEFFS][NUM_POINTS] = '{
		'{qmicro(64'd60000), qmicro(64'd110000), qmicro(64'd110300), qmicro(64'd97150),
		  qmicro(64'd78030), qmicro(64'd71640), qmicro(64'd63800)},
		'{CW'(0), CW'(0), CW'(0), CW'(0), CW'(0), CW'(0), CW'(0)},
		'{qmicro(64'd135400000), qmicro(64'd10240000), qmicro(64'd1463000),
		  qmicro(64'd199400), qmicro(64'd29170), qmicro(64'd16410), qmicro(64'd8302)}
	};

	typedef struct packed {
		logic [DW-1:0] d;
		logic [DW-1:0] wd;
		logic [DW-1:0] w;
		logic [RW-1:0] recip;
	} seg_info_t;

	typedef struct packed {
		logic [CW-1:0] lo;
		logic [CW-1:0] hi;
	} coeff_pair_t;

endpackage

`default_nettype wire

/* design/attenuation_table_interpolator.sv */
// Throughput: one transaction per cycle while the output is not stalled; eight register
// stages (compare, segment select and fetch, multiply, sum, reciprocal multiply,
// quotient, back multiply, correction).
// A stalled output holds; bubbles in the pipe still take new transactions.
// Reset (arst_n low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// attenuation_table_interpolator
// Piecewise linear interpolation of Compton, pair production and
// photoelectric attenuation over a constant seven-point energy table.
// ----------------------------------------------------------------------------
`default_nettype none

module attenuation_table_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        energy_valid,
	output logic        energy_stall,
	input  logic [19:0] energy_ev,
	output logic        coeff_valid,
	input  logic        coeff_stall,
	output logic [23:0] compton_coeff,
	output logic [23:0] pair_coeff,
	output logic [23:0] photo_coeff
);

	localparam int NS = atint_pkg::NUM_STAGES;

	logic [NS-1:0]               stage_valid_q;
	logic [NS-1:0]               en;
	atint_pkg::seg_info_t        info_s2;
	atint_pkg::coeff_pair_t      pair_s2 [atint_pkg::NUM_COEFFS];
	logic [atint_pkg::OW-1:0]    lane_coeff [atint_pkg::NUM_COEFFS];

	always_comb begin
		en[NS-1] = !stage_valid_q[NS-1] || !coeff_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !stage_valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[0]) begin
				stage_valid_q[0] <= energy_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	assign energy_stall = !en[0];
	assign coeff_valid  = stage_valid_q[NS-1];

	atint_locate u_locate (
		.clk       (clk),
		.en        (en[1:0]),
		.energy_ev (energy_ev),
		.info_s2   (info_s2),
		.pair_s2   (pair_s2)
	);

	for (genvar c = 0; c < atint_pkg::NUM_COEFFS; c++) begin : g_lane
		atint_lane u_lane (
			.clk      (clk),
			.en       (en[7:2]),
			.info_s2  (info_s2),
			.pair_s2  (pair_s2[c]),
			.coeff_s8 (lane_coeff[c])
		);
	end

	assign compton_coeff = lane_coeff[atint_pkg::COMPTON];
	assign pair_coeff    = lane_coeff[atint_pkg::PAIR];
	assign photo_coeff   = lane_coeff[atint_pkg::PHOTO];

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		energy_stall |-> (coeff_valid && coeff_stall))
		else $error("input stalled while output stage can advance");

	a_count_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(stage_valid_q) ==
			$past($countones(stage_valid_q))
			+ $past(int'(energy_valid && !energy_stall))
			- $past(int'(coeff_valid && !coeff_stall))))
		else $error("transaction lost or duplicated in pipeline");
`endif

endmodule

`default_nettype wire

/* design/atint_locate.sv */
// ----------------------------------------------------------------------------
// atint_locate
// Segment search: compares the energy against every breakpoint, picks the
// segment and offset, clamps the ends, and fetches the enclosing table entries.
// ----------------------------------------------------------------------------
`default_nettype none

module atint_locate (
	input  logic                             clk,
	input  logic [1:0]                       en,
	input  logic [atint_pkg::EW-1:0]         energy_ev,
	output atint_pkg::seg_info_t             info_s2,
	output atint_pkg::coeff_pair_t           pair_s2 [atint_pkg::NUM_COEFFS]
);

	logic [atint_pkg::EW-1:0]       energy_s1;
	logic [atint_pkg::NUM_SEGS-1:0] gt_s1;
	logic                           hi_s1;

	logic [atint_pkg::SEG_W-1:0]    seg;
	logic [atint_pkg::PT_W-1:0]     seg_hi;
	logic [atint_pkg::DW-1:0]       d;
	logic [atint_pkg::DW-1:0]       w;
	logic [atint_pkg::EW-1:0]       diff;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			energy_s1 <= energy_ev;
			hi_s1     <= energy_ev >= atint_pkg::BRK_EV[atint_pkg::NUM_POINTS-1];
			for (int k = 0; k < atint_pkg::NUM_SEGS; k++) begin
				gt_s1[k] <= energy_ev > atint_pkg::BRK_EV[k];
			end
		end
	end

	always_comb begin
		seg = '0;
		for (int k = 1; k < atint_pkg::NUM_SEGS; k++) begin
			if (gt_s1[k]) begin
				seg = atint_pkg::SEG_W'(k);
			end
		end
		seg_hi = atint_pkg::PT_W'(seg) + atint_pkg::PT_W'(1);
		w      = atint_pkg::SEG_WIDTH[seg];
		diff   = energy_s1 - atint_pkg::BRK_EV[seg];
		if (hi_s1) begin
			d = w;
		end else if (!gt_s1[0]) begin
			d = '0;
		end else begin
			d = diff[atint_pkg::DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			info_s2.d     <= d;
			info_s2.wd    <= w - d;
			info_s2.w     <= w;
			info_s2.recip <= atint_pkg::SEG_RECIP[seg];
			for (int c = 0; c < atint_pkg::NUM_COEFFS; c++) begin
				pair_s2[c].lo <= atint_pkg::COEFF_Q24[c][seg];
				pair_s2[c].hi <= atint_pkg::COEFF_Q24[c][seg_hi];
			end
		end
	end

endmodule

`default_nettype wire

/* design/atint_lane.sv */
// ----------------------------------------------------------------------------
// atint_lane
// One coefficient lane: weighted sum of the two table entries, then the
// division by the segment width through its reciprocal with a one-step
// correction, and saturation to the output width.
// ----------------------------------------------------------------------------
`default_nettype none

module atint_lane (
	input  logic                        clk,
	input  logic [5:0]                  en,
	input  atint_pkg::seg_info_t        info_s2,
	input  atint_pkg::coeff_pair_t      pair_s2,
	output logic [atint_pkg::OW-1:0]    coeff_s8
);

	logic [atint_pkg::PW-1:0]    prod_lo_s3;
	logic [atint_pkg::PW-1:0]    prod_hi_s3;
	logic [atint_pkg::DW-1:0]    w_s3;
	logic [atint_pkg::RW-1:0]    recip_s3;

	logic [atint_pkg::PW-1:0]    num;
	logic [atint_pkg::NW-1:0]    n_s4;
	logic [atint_pkg::DW-1:0]    w_s4;
	logic [atint_pkg::RW-1:0]    recip_s4;

	logic [atint_pkg::PPH-1:0]   pp_hi_s5;
	logic [atint_pkg::PPL-1:0]   pp_lo_s5;
	logic [atint_pkg::REM_W-1:0] n_low_s5;
	logic [atint_pkg::DW-1:0]    w_s5;

	logic [atint_pkg::SW-1:0]    sum;
	logic [atint_pkg::RW-1:0]    q_s6;
	logic [atint_pkg::REM_W-1:0] n_low_s6;
	logic [atint_pkg::DW-1:0]    w_s6;

	logic [atint_pkg::MW-1:0]    qw;
	logic [atint_pkg::REM_W-1:0] qw_low_s7;
	logic [atint_pkg::RW-1:0]    q_s7;
	logic [atint_pkg::REM_W-1:0] n_low_s7;
	logic [atint_pkg::DW-1:0]    w_s7;

	logic [atint_pkg::REM_W-1:0] rem;
	logic [atint_pkg::RW:0]      q_fix;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_lo_s3 <= atint_pkg::PW'(pair_s2.lo) * atint_pkg::PW'(info_s2.wd);
			prod_hi_s3 <= atint_pkg::PW'(pair_s2.hi) * atint_pkg::PW'(info_s2.d);
			w_s3       <= info_s2.w;
			recip_s3   <= info_s2.recip;
		end
	end

	assign num = prod_lo_s3 + prod_hi_s3;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s4     <= num[atint_pkg::PW-1:atint_pkg::FRAC_DROP];
			w_s4     <= w_s3;
			recip_s4 <= recip_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pp_hi_s5 <= atint_pkg::PPH'(n_s4[atint_pkg::NW-1:atint_pkg::HW])
				* atint_pkg::PPH'(recip_s4);
			pp_lo_s5 <= atint_pkg::PPL'(n_s4[atint_pkg::HW-1:0]) * atint_pkg::PPL'(recip_s4);
			n_low_s5 <= n_s4[atint_pkg::REM_W-1:0];
			w_s5     <= w_s4;
		end
	end

	assign sum = {pp_hi_s5, atint_pkg::HW'(0)} + atint_pkg::SW'(pp_lo_s5);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q_s6     <= sum[atint_pkg::SW-1:atint_pkg::NW];
			n_low_s6 <= n_low_s5;
			w_s6     <= w_s5;
		end
	end

	assign qw = atint_pkg::MW'(q_s6) * atint_pkg::MW'(w_s6);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			qw_low_s7 <= qw[atint_pkg::REM_W-1:0];
			q_s7      <= q_s6;
			n_low_s7  <= n_low_s6;
			w_s7      <= w_s6;
		end
	end

	assign rem   = n_low_s7 - qw_low_s7;
	assign q_fix = (atint_pkg::RW+1)'(q_s7)
		+ (atint_pkg::RW+1)'(rem >= atint_pkg::REM_W'(w_s7));

	always_ff @(posedge clk) begin
		if (en[5]) begin
			if (q_fix[atint_pkg::RW:atint_pkg::OW] != '0) begin
				coeff_s8 <= '1;
			end else begin
				coeff_s8 <= q_fix[atint_pkg::OW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* sim/attenuation_table_interpolator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attenuation_table_interpolator_tb
// Self-checking bench for the attenuation table interpolator: drives photon
// energies with bursty valid and a patterned output stall, predicts the three
// interpolated coefficients per transaction and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module attenuation_table_interpolator_tb;

	typedef struct packed {
		logic [atint_pkg::EW-1:0] energy;
		logic [atint_pkg::OW-1:0] compton;
		logic [atint_pkg::OW-1:0] pair;
		logic [atint_pkg::OW-1:0] photo;
	} coeff_set_t;

	class coeff_scoreboard;
		longint unsigned brk_ev   [atint_pkg::NUM_POINTS];
		longint unsigned coeff_tab[atint_pkg::NUM_COEFFS][atint_pkg::NUM_POINTS];
		coeff_set_t      pending_q[$];
		int unsigned     fail_count;

		function new();
			longint unsigned compton_micro [atint_pkg::NUM_POINTS];
			longint unsigned photo_micro   [atint_pkg::NUM_POINTS];
			brk_ev        = '{10000, 50000, 100000, 200000, 400000, 500000, 662000};
			compton_micro = '{60000, 110000, 110300, 97150, 78030, 71640, 63800};
			photo_micro   = '{135400000, 10240000, 1463000, 199400, 29170, 16410, 8302};
			for (int i = 0; i < atint_pkg::NUM_POINTS; i++) begin
				coeff_tab[atint_pkg::COMPTON][i] = micro_to_q24(compton_micro[i]);
				coeff_tab[atint_pkg::PAIR][i]    = 0;
				coeff_tab[atint_pkg::PHOTO][i]   = micro_to_q24(photo_micro[i]);
			end
			fail_count = 0;
		endfunction

		function longint unsigned micro_to_q24(longint unsigned m);
			return (m * 64'd16777216 + 64'd500000) / 64'd1000000;
		endfunction

		function logic [atint_pkg::OW-1:0] clip_out(longint unsigned v);
			return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[atint_pkg::OW-1:0];
		endfunction

		function logic [atint_pkg::OW-1:0] interp_coeff(int c, int seg,
				longint unsigned d, longint unsigned w);
			longint unsigned num;
			num = coeff_tab[c][seg] * (w - d) + coeff_tab[c][seg+1] * d;
			return clip_out(num / (w << atint_pkg::FRAC_DROP));
		endfunction

		function coeff_set_t lookup_energy(logic [atint_pkg::EW-1:0] e);
			coeff_set_t      r;
			longint unsigned ev;
			int              pt;
			int              seg;
			ev       = e;
			r.energy = e;
			if (ev <= brk_ev[0] || ev >= brk_ev[atint_pkg::NUM_POINTS-1]) begin
				pt        = (ev <= brk_ev[0]) ? 0 : atint_pkg::NUM_POINTS - 1;
				r.compton = clip_out(coeff_tab[atint_pkg::COMPTON][pt] >> atint_pkg::FRAC_DROP);
				r.pair    = clip_out(coeff_tab[atint_pkg::PAIR][pt] >> atint_pkg::FRAC_DROP);
				r.photo   = clip_out(coeff_tab[atint_pkg::PHOTO][pt] >> atint_pkg::FRAC_DROP);
			end else begin
				seg = 0;
				while (seg + 1 < atint_pkg::NUM_POINTS - 1 && brk_ev[seg+1] < ev)
					seg++;
				r.compton = interp_coeff(atint_pkg::COMPTON, seg, ev - brk_ev[seg],
					brk_ev[seg+1] - brk_ev[seg]);
				r.pair    = interp_coeff(atint_pkg::PAIR, seg, ev - brk_ev[seg],
					brk_ev[seg+1] - brk_ev[seg]);
				r.photo   = interp_coeff(atint_pkg::PHOTO, seg, ev - brk_ev[seg],
					brk_ev[seg+1] - brk_ev[seg]);
			end
			return r;
		endfunction

		function void note_energy(logic [atint_pkg::EW-1:0] e);
			pending_q.push_back(lookup_energy(e));
		endfunction

		task report_mismatch(string what, logic [atint_pkg::EW-1:0] e,
				logic [atint_pkg::OW-1:0] got, logic [atint_pkg::OW-1:0] want);
			$display("mismatch %s: energy %0d got 0x%06h expected 0x%06h",
				what, e, got, want);
			fail_count++;
		endtask

		task check_coeffs(logic [atint_pkg::OW-1:0] compton,
				logic [atint_pkg::OW-1:0] pair, logic [atint_pkg::OW-1:0] photo);
			coeff_set_t want;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected transaction", '0, compton, '0);
				return;
			end
			want = pending_q.pop_front();
			if (compton !== want.compton)
				report_mismatch("compton_coeff", want.energy, compton, want.compton);
			if (pair !== want.pair)
				report_mismatch("pair_coeff", want.energy, pair, want.pair);
			if (photo !== want.photo)
				report_mismatch("photo_coeff", want.energy, photo, want.photo);
		endtask
	endclass

	localparam int RANDOM_ITEMS   = 1430;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLDOFF_CYCLES = 300;

	logic                     clk;
	logic                     arst_n;
	logic                     energy_valid;
	logic                     energy_stall;
	logic [atint_pkg::EW-1:0] energy_ev;
	logic                     coeff_valid;
	logic                     coeff_stall;
	logic [atint_pkg::OW-1:0] compton_coeff;
	logic [atint_pkg::OW-1:0] pair_coeff;
	logic [atint_pkg::OW-1:0] photo_coeff;

	coeff_scoreboard sb;
	int unsigned     quiet_cycles = 0;

	attenuation_table_interpolator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.energy_valid (energy_valid),
		.energy_stall (energy_stall),
		.energy_ev    (energy_ev),
		.coeff_valid  (coeff_valid),
		.coeff_stall  (coeff_stall),
		.compton_coeff(compton_coeff),
		.pair_coeff   (pair_coeff),
		.photo_coeff  (photo_coeff)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_energy(input logic [atint_pkg::EW-1:0] e);
		@(negedge clk);
		energy_valid <= 1'b1;
		energy_ev    <= e;
		do
			@(posedge clk);
		while (!(energy_valid && !energy_stall));
		sb.note_energy(e);
	endtask

	task automatic idle_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			energy_valid <= 1'b0;
			energy_ev    <= atint_pkg::EW'($urandom);
		end
	endtask

	function automatic logic [atint_pkg::EW-1:0] pick_energy();
		int unsigned mode;
		int          e;
		mode = $urandom_range(0, 9);
		case (mode)
			6: begin
				e = int'(sb.brk_ev[$urandom_range(0, atint_pkg::NUM_POINTS - 1)])
					+ $urandom_range(0, 6) - 3;
				return atint_pkg::EW'(e);
			end
			7:       return atint_pkg::EW'($urandom);
			8:       return atint_pkg::EW'($urandom_range(0, 10000));
			9:       return atint_pkg::EW'($urandom_range(662000, 1048575));
			default: return atint_pkg::EW'($urandom_range(10000, 662000));
		endcase
	endfunction

	// receiver stall pattern, with one long hold-off to back the pipe up
	initial begin
		int unsigned mode;
		int unsigned len;
		int unsigned segs;
		coeff_stall = 1'b0;
		segs        = 0;
		wait (arst_n);
		forever begin
			if (segs == 10) begin
				repeat (HOLDOFF_CYCLES) begin
					@(negedge clk);
					coeff_stall <= 1'b1;
				end
			end
			segs++;
			mode = $urandom_range(0, 3);
			len  = $urandom_range(5, 60);
			for (int k = 0; k < len; k++) begin
				@(negedge clk);
				case (mode)
					0:       coeff_stall <= 1'b0;
					1:       coeff_stall <= ($urandom_range(0, 3) == 0);
					2:       coeff_stall <= ($urandom_range(0, 3) != 0);
					default: coeff_stall <= k[0];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && coeff_valid && !coeff_stall)
			sb.check_coeffs(compton_coeff, pair_coeff, photo_coeff);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((energy_valid && !energy_stall) || (coeff_valid && !coeff_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [atint_pkg::EW-1:0] directed_q[$];
		int                       sent;
		int                       burst;
		int                       gap;
		sb           = new();
		arst_n       = 1'b0;
		energy_valid = 1'b0;
		energy_ev    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_q = '{20'd0, 20'd1, 20'd9999, 20'd10000, 20'd10001, 20'd49999,
			20'd50000, 20'd50001, 20'd100000, 20'd100001, 20'd199999, 20'd200000,
			20'd300000, 20'd400000, 20'd400001, 20'd500000, 20'd500001, 20'd661999,
			20'd662000, 20'd662001, 20'hFFFFF, 20'hAAAAA, 20'h55555, 20'd30000};
		foreach (directed_q[i])
			send_energy(directed_q[i]);
		idle_sender(3);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				send_energy(pick_energy());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0)
				idle_sender(gap);
		end
		idle_sender(1);

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.fail_count == 0 && sb.pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
